[hdl/jsu_pkg.sv]
// Shared types and constants for the JSON string unescaper.
package jsu_pkg;

  // Decoder state of the front end
  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_HEX    = 2'd2
  } mode_t;

  // Default number of entries in the front-to-back queue
  localparam int QUEUE_DEPTH = 2;

  // Characters the front end looks for
  localparam logic [7:0] CHAR_BSLASH = 8'h5c;
  localparam logic [7:0] CHAR_QUOTE  = 8'h22;
  localparam logic [7:0] CHAR_SLASH  = 8'h2f;
  localparam logic [7:0] CHAR_B      = 8'h62;
  localparam logic [7:0] CHAR_F      = 8'h66;
  localparam logic [7:0] CHAR_N      = 8'h6e;
  localparam logic [7:0] CHAR_R      = 8'h72;
  localparam logic [7:0] CHAR_T      = 8'h74;
  localparam logic [7:0] CHAR_U      = 8'h75;

  // Bytes produced by the short escapes
  localparam logic [7:0] BYTE_BS = 8'h08;
  localparam logic [7:0] BYTE_FF = 8'h0c;
  localparam logic [7:0] BYTE_LF = 8'h0a;
  localparam logic [7:0] BYTE_CR = 8'h0d;
  localparam logic [7:0] BYTE_HT = 8'h09;

  // One classified input byte: up to three data bytes, then an optional status
  typedef struct packed {
    logic            ok;
    logic            has_status;
    logic [2:0][7:0] bytes;
    logic [1:0]      nbytes;
  } cmd_t;

endpackage

[hdl/json_string_unescaper_top.sv]
// Top level of the JSON string unescaper.
//
//  channel  | dir | tdata     | tuser                     | tlast
//  ---------+-----+-----------+---------------------------+--------------
//  s_axis   | in  | in_byte   | -                         | last_byte
//  m_axis   | out | out_byte  | [0] has_byte [1] string_ok| end_of_string
//
// One input byte is taken per cycle while the command queue has room. An
// input byte turns into zero to four output beats; the back end sends one
// beat per cycle unless the output stalls, so a completed \u escape with a
// status beat holds the head command for up to four beats. Reset clears the
// decode state, queue and out_valid; the queue absorbs either side's stalls.
module json_string_unescaper_top #(
  parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [1:0] m_tuser,   // [0] has_byte, [1] string_ok
  output logic       m_tlast
);
  import jsu_pkg::*;

  logic push, pop, q_full, q_empty;
  cmd_t push_data, pop_data;
  logic out_has, out_ok;

  jsu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .in_last   (s_tlast),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  jsu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .q_pop     (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_has   (out_has),
    .out_ok    (out_ok),
    .out_end   (m_tlast)
  );

  assign m_tuser = {out_ok, out_has};

endmodule

[hdl/jsu_front.sv]
// Front end: accepts raw bytes, tracks escape state, builds output commands.
module jsu_front (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [7:0]   in_byte,
  input  logic         in_last,
  output logic         push,
  output jsu_pkg::cmd_t push_data,
  input  logic         q_full
);
  import jsu_pkg::*;

  mode_t       mode, mode_next;
  logic [1:0]  digits_seen, digits_seen_next;
  logic [11:0] code_unit, code_unit_next;   // only the low 12 bits shift on
  logic        digit_bad, digit_bad_next;
  logic        error_seen, error_seen_next;

  logic        accept;
  logic [4:0]  hex_val;                     // bit 4 set: not a hex digit
  logic [15:0] cu;
  logic        bad_now;
  logic        err_end;
  cmd_t        cmd;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Hex digit decode
  always_comb begin
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_val = {1'b0, in_byte[3:0]};
    end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                 (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
      hex_val = {1'b0, in_byte[3:0] + 4'd9};
    end else begin
      hex_val = 5'h10;
    end
  end

  assign cu      = {code_unit, hex_val[3:0]};
  assign bad_now = digit_bad || hex_val[4];

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_NORMAL;
      digits_seen <= 2'd0;
      code_unit   <= 12'd0;
      digit_bad   <= 1'b0;
      error_seen  <= 1'b0;
    end else if (accept) begin
      mode        <= mode_next;
      digits_seen <= digits_seen_next;
      code_unit   <= code_unit_next;
      digit_bad   <= digit_bad_next;
      error_seen  <= error_seen_next;
    end
  end

  // Next state and command
  always_comb begin
    mode_next        = mode;
    digits_seen_next = digits_seen;
    code_unit_next   = code_unit;
    digit_bad_next   = digit_bad;
    error_seen_next  = error_seen;
    cmd              = '0;
    err_end          = 1'b0;

    unique case (mode)
      MODE_ESCAPE: begin
        mode_next     = MODE_NORMAL;
        cmd.nbytes    = 2'd1;
        cmd.bytes[0]  = in_byte;
        unique case (in_byte) inside
          CHAR_QUOTE, CHAR_BSLASH, CHAR_SLASH: ;
          CHAR_B: cmd.bytes[0] = BYTE_BS;
          CHAR_F: cmd.bytes[0] = BYTE_FF;
          CHAR_N: cmd.bytes[0] = BYTE_LF;
          CHAR_R: cmd.bytes[0] = BYTE_CR;
          CHAR_T: cmd.bytes[0] = BYTE_HT;
          CHAR_U: begin
            mode_next        = MODE_HEX;
            digits_seen_next = 2'd0;
            code_unit_next   = 12'd0;
            digit_bad_next   = 1'b0;
            cmd.nbytes       = 2'd0;
          end
          default: error_seen_next = 1'b1;
        endcase
      end
      MODE_HEX: begin
        code_unit_next = cu[11:0];
        digit_bad_next = bad_now;
        if (digits_seen == 2'd3) begin
          mode_next        = MODE_NORMAL;
          digits_seen_next = 2'd0;
          digit_bad_next   = 1'b0;
          if (bad_now) begin
            error_seen_next = 1'b1;
          end else if (cu[15:11] != 5'b11011) begin
            // UTF-8 encoding of one code unit; surrogates give nothing
            if (cu[15:7] == 9'd0) begin
              cmd.nbytes   = 2'd1;
              cmd.bytes[0] = cu[7:0];
            end else if (cu[15:11] == 5'd0) begin
              cmd.nbytes   = 2'd2;
              cmd.bytes[0] = {3'b110, cu[10:6]};
              cmd.bytes[1] = {2'b10, cu[5:0]};
            end else begin
              cmd.nbytes   = 2'd3;
              cmd.bytes[0] = {4'b1110, cu[15:12]};
              cmd.bytes[1] = {2'b10, cu[11:6]};
              cmd.bytes[2] = {2'b10, cu[5:0]};
            end
          end
        end else begin
          digits_seen_next = digits_seen + 2'd1;
        end
      end
      default: begin
        if (in_byte == CHAR_BSLASH) begin
          mode_next = MODE_ESCAPE;
        end else begin
          cmd.nbytes   = 2'd1;
          cmd.bytes[0] = in_byte;
        end
      end
    endcase

    // End of string: status beat, then back to the reset state
    if (in_last) begin
      err_end          = error_seen_next || (mode_next != MODE_NORMAL);
      cmd.has_status   = 1'b1;
      cmd.ok           = !err_end;
      mode_next        = MODE_NORMAL;
      digits_seen_next = 2'd0;
      code_unit_next   = 12'd0;
      digit_bad_next   = 1'b0;
      error_seen_next  = 1'b0;
    end
  end

  assign push      = accept && ((cmd.nbytes != 2'd0) || cmd.has_status);
  assign push_data = cmd;

endmodule

[hdl/jsu_queue.sv]
// Short command queue between the front end and the back end.
module jsu_queue #(
  parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  jsu_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output jsu_pkg::cmd_t pop_data,
  output logic          empty
);
  import jsu_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hdl/jsu_back.sv]
// Back end: expands queued commands into output beats through a register.
module jsu_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  jsu_pkg::cmd_t q_data,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_has,
  output logic          out_ok,
  output logic          out_end
);
  import jsu_pkg::*;

  logic [1:0] idx;          // beat position within the head command
  logic [2:0] total;
  logic       load;
  logic       is_data;
  logic       last_beat;
  logic [7:0] sel_byte;

  assign total     = {1'b0, q_data.nbytes} + {2'b0, q_data.has_status};
  assign load      = !q_empty && (!out_valid || out_ready);
  assign last_beat = (({1'b0, idx} + 3'd1) == total);
  assign is_data   = (idx < q_data.nbytes);
  assign q_pop     = load && last_beat;

  // Byte select for the current beat
  always_comb begin
    case (idx)
      2'd0:    sel_byte = q_data.bytes[0];
      2'd1:    sel_byte = q_data.bytes[1];
      default: sel_byte = q_data.bytes[2];
    endcase
  end

  // Beat counter and valid
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        idx       <= last_beat ? 2'd0 : idx + 2'd1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= is_data ? sel_byte : 8'h00;
      out_has  <= is_data;
      out_end  <= !is_data;
      out_ok   <= !is_data && q_data.ok;
    end
  end

endmodule

[tb/json_string_unescaper_top_tb.sv]
// Self-checking testbench for json_string_unescaper_top: random escaped strings vs a predictor.
module json_string_unescaper_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jsu_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_WAIT  = 20;
  localparam int PHASE_BYTES = 75;
  localparam int MAX_PRINTS  = 30;

  // One input beat and one output beat
  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       eos;
    logic       ok;
  } out_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;
  logic       m_tlast;

  json_string_unescaper_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  in_beat_t   pending_bytes[$];
  out_beat_t  unescaped_q[$];
  logic [7:0] str_q[$];

  int send_idle = 0;
  int recv_idle = 0;
  logic hold_go = 1'b0;
  int hold_left = 0;
  logic hold_used = 1'b0;
  int cycle_cnt = 0;
  int err_count = 0;
  int n_in = 0;
  int n_out = 0;
  int n_strings = 0;

  // Predictor state
  mode_t       dec_mode  = MODE_NORMAL;
  logic [1:0]  hex_count = '0;
  logic [15:0] hex_acc   = '0;
  logic        hex_bad   = 1'b0;
  logic        str_err   = 1'b0;

  // Hex digit value, bit 4 set when the byte is not a hex digit
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 10)};
    if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 10)};
    return 5'h10;
  endfunction

  task automatic push_data(input logic [7:0] b);
    out_beat_t ob;
    ob.data = b;
    ob.has  = 1'b1;
    ob.eos  = 1'b0;
    ob.ok   = 1'b0;
    unescaped_q.insert(unescaped_q.size(), ob);
  endtask

  // UTF-8 encoding of one code unit
  task automatic push_utf8(input logic [15:0] cu);
    if (cu < 16'h0080) begin
      push_data(cu[7:0]);
    end else if (cu < 16'h0800) begin
      push_data(8'hc0 | 8'(cu >> 6));
      push_data(8'h80 | 8'(cu[5:0]));
    end else begin
      push_data(8'he0 | 8'(cu >> 12));
      push_data(8'h80 | 8'(cu[11:6]));
      push_data(8'h80 | 8'(cu[5:0]));
    end
  endtask

  // Predict the beats caused by one accepted input byte
  task automatic unescape_byte(input logic [7:0] c, input logic is_last);
    logic [4:0] v;
    out_beat_t  st;
    case (dec_mode)
      MODE_ESCAPE: begin
        dec_mode = MODE_NORMAL;
        case (c)
          CHAR_QUOTE, CHAR_BSLASH, CHAR_SLASH: push_data(c);
          CHAR_B: push_data(BYTE_BS);
          CHAR_F: push_data(BYTE_FF);
          CHAR_N: push_data(BYTE_LF);
          CHAR_R: push_data(BYTE_CR);
          CHAR_T: push_data(BYTE_HT);
          CHAR_U: begin
            dec_mode  = MODE_HEX;
            hex_count = '0;
            hex_acc   = '0;
            hex_bad   = 1'b0;
          end
          default: begin
            str_err = 1'b1;
            push_data(c);
          end
        endcase
      end
      MODE_HEX: begin
        v = hex_nibble(c);
        if (v[4]) hex_bad = 1'b1;
        hex_acc = {hex_acc[11:0], v[3:0]};
        if (hex_count == 2'd3) begin
          dec_mode  = MODE_NORMAL;
          hex_count = '0;
          if (hex_bad) str_err = 1'b1;
          else if (hex_acc < 16'hd800 || hex_acc > 16'hdfff) push_utf8(hex_acc);
          hex_bad = 1'b0;
        end else begin
          hex_count = hex_count + 2'd1;
        end
      end
      default: begin
        if (c == CHAR_BSLASH) dec_mode = MODE_ESCAPE;
        else push_data(c);
      end
    endcase
    // Status beat closes the string
    if (is_last) begin
      if (dec_mode != MODE_NORMAL) str_err = 1'b1;
      st.data = 8'h00;
      st.has  = 1'b0;
      st.eos  = 1'b1;
      st.ok   = !str_err;
      unescaped_q.insert(unescaped_q.size(), st);
      dec_mode  = MODE_NORMAL;
      hex_count = '0;
      hex_acc   = '0;
      hex_bad   = 1'b0;
      str_err   = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
    if (err_count < MAX_PRINTS)
      $display("[%0t] mismatch on %s: got %02h, expected %02h", $realtime, what, got, want);
    err_count++;
  endtask

  // Driver: offers queued bytes, predicts on each accepted beat
  always @(posedge clk) begin
    in_beat_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'h00;
      s_tlast  <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        unescape_byte(s_tdata, s_tlast);
        n_in++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
          it = pending_bytes.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= it.data;
          s_tlast  <= it.is_last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted output beat against the oldest prediction
  always @(posedge clk) begin
    out_beat_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_out++;
        if (unescaped_q.size() == 0) begin
          report_mismatch("unexpected beat", m_tdata, 8'h00);
        end else begin
          want = unescaped_q.pop_front();
          if (m_tdata !== want.data)
            report_mismatch("out_byte", m_tdata, want.data);
          if (m_tuser[0] !== want.has)
            report_mismatch("has_byte", {7'd0, m_tuser[0]}, {7'd0, want.has});
          if (m_tlast !== want.eos)
            report_mismatch("end_of_string", {7'd0, m_tlast}, {7'd0, want.eos});
          if (m_tuser[1] !== want.ok)
            report_mismatch("string_ok", {7'd0, m_tuser[1]}, {7'd0, want.ok});
        end
      end
      m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_go && !hold_used) begin
      hold_left <= LONG_HOLD;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("json_string_unescaper_top_tb NOT OK");
      $finish;
    end
  end

  // ---- stimulus helpers ----

  function automatic logic is_escape_char(input logic [7:0] b);
    return b == CHAR_QUOTE || b == CHAR_BSLASH || b == CHAR_SLASH || b == CHAR_B ||
           b == CHAR_F || b == CHAR_N || b == CHAR_R || b == CHAR_T || b == CHAR_U;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 10) return 8'("0" + n);
    return 8'(($urandom_range(0, 1) ? "A" : "a") + n - 10);
  endfunction

  function automatic logic [7:0] rand_plain();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CHAR_BSLASH);
    return b;
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) str_q.insert(str_q.size(), s[i]);
  endtask

  // Move the built string into the pending queue, marking its final byte
  task automatic flush_string(output int nbytes);
    in_beat_t ib;
    nbytes = str_q.size();
    for (int i = 0; i < nbytes; i++) begin
      ib.data    = str_q[i];
      ib.is_last = (i == nbytes - 1);
      pending_bytes.insert(pending_bytes.size(), ib);
    end
    str_q.delete();
    n_strings++;
  endtask

  // A \u escape; bad_pos in 0..3 plants one non-hex digit, 4 plants none
  task automatic add_hex_escape(input logic [15:0] cu, input int bad_pos);
    logic [7:0] b;
    logic [4:0] nv;
    str_q.insert(str_q.size(), CHAR_BSLASH);
    str_q.insert(str_q.size(), CHAR_U);
    for (int i = 0; i < 4; i++) begin
      if (i == bad_pos) begin
        if ($urandom_range(0, 3) == 0) begin
          b = CHAR_BSLASH;
        end else begin
          do begin
            b  = 8'($urandom_range(0, 255));
            nv = hex_nibble(b);
          end while (!nv[4]);
        end
        str_q.insert(str_q.size(), b);
      end else begin
        str_q.insert(str_q.size(), hex_char(cu[15 - 4*i -: 4]));
      end
    end
  endtask

  // One random string: mostly well-formed escapes with random content
  task automatic build_string(output int nbytes);
    int ntok;
    int pick;
    logic [7:0] b;
    logic [15:0] cu;
    logic [7:0] short_esc[8];
    short_esc = '{CHAR_QUOTE, CHAR_BSLASH, CHAR_SLASH, CHAR_B, CHAR_F, CHAR_N, CHAR_R, CHAR_T};
    ntok = $urandom_range(1, 8);
    for (int t = 0; t < ntok; t++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        str_q.insert(str_q.size(), rand_plain());
      end else if (pick < 62) begin
        str_q.insert(str_q.size(), CHAR_BSLASH);
        str_q.insert(str_q.size(), short_esc[$urandom_range(0, 7)]);
      end else if (pick < 85) begin
        case ($urandom_range(0, 3))
          0: cu = 16'($urandom_range(16'h0000, 16'h007f));
          1: cu = 16'($urandom_range(16'h0080, 16'h07ff));
          2: cu = 16'($urandom_range(16'h0800, 16'hffff));
          default: cu = 16'($urandom_range(16'hd800, 16'hdfff));
        endcase
        add_hex_escape(cu, 4);
      end else if (pick < 91) begin
        add_hex_escape(16'($urandom_range(0, 16'hffff)), $urandom_range(0, 3));
      end else if (pick < 96) begin
        do b = 8'($urandom_range(0, 255)); while (is_escape_char(b));
        str_q.insert(str_q.size(), CHAR_BSLASH);
        str_q.insert(str_q.size(), b);
      end else begin
        // raw noise, backslash allowed
        str_q.insert(str_q.size(), 8'($urandom_range(0, 255)));
      end
    end
    // Occasionally break the end of the string
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      str_q.insert(str_q.size(), CHAR_BSLASH);
    end else if (pick < 16) begin
      str_q.insert(str_q.size(), CHAR_BSLASH);
      str_q.insert(str_q.size(), CHAR_U);
      repeat ($urandom_range(0, 3))
        str_q.insert(str_q.size(), hex_char(4'($urandom_range(0, 15))));
    end
    flush_string(nbytes);
  endtask

  task automatic drain();
    while (pending_bytes.size() != 0 || s_tvalid || unescaped_q.size() != 0) @(posedge clk);
  endtask

  task automatic random_phase(input int target);
    int n;
    int cnt;
    n = 0;
    while (n < target) begin
      build_string(cnt);
      n += cnt;
    end
  endtask

  // ---- test sequence ----
  initial begin
    int cnt;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Phase 1: sender idles often, receiver idles more
    @(posedge clk);
    send_idle <= 38;
    recv_idle <= 73;
    add_text("\\u0000");  flush_string(cnt);  // code unit zero
    add_text("\\uDFFF");  flush_string(cnt);  // surrogate, silent
    add_text("\\uz\\0F"); flush_string(cnt);  // bad digits, backslash eaten as digit
    add_text("\\W");      flush_string(cnt);  // unknown escape
    str_q.insert(str_q.size(), 8'hff);
    add_text("\\");       flush_string(cnt);  // trailing backslash
    add_text("\\u1");     flush_string(cnt);  // unfinished hex escape
    str_q.insert(str_q.size(), 8'h00);
    flush_string(cnt);
    random_phase(PHASE_BYTES);
    drain();

    // Phase 2: roles swapped
    @(posedge clk);
    send_idle <= 73;
    recv_idle <= 38;
    random_phase(PHASE_BYTES);
    drain();

    // Phase 3: no idling, with one long receiver hold-off while bytes keep coming
    @(posedge clk);
    send_idle <= 0;
    recv_idle <= 0;
    hold_go   <= 1'b1;
    random_phase(PHASE_BYTES);
    drain();

    repeat (DRAIN_WAIT) @(posedge clk);
    $display("covered %0d strings: %0d input bytes in, %0d output beats checked",
             n_strings, n_in, n_out);
    $display("short and unicode escapes, bad digits, surrogates, broken endings, stalls");
    if (err_count == 0 && unescaped_q.size() == 0) begin
      $display("json_string_unescaper_top_tb OK");
    end else begin
      $display("%0d mismatches, %0d beats still expected", err_count, unescaped_q.size());
      $display("json_string_unescaper_top_tb NOT OK");
    end
    $finish;
  end

endmodule

[files.f]
hdl/jsu_pkg.sv
hdl/jsu_front.sv
hdl/jsu_queue.sv
hdl/jsu_back.sv
hdl/json_string_unescaper_top.sv
tb/json_string_unescaper_top_tb.sv
